// File: hdl/amix_pkg.sv
// Shared types and constants for the two-source chunked audio mixer.
package amix_pkg;

  localparam int IN_SAMPLE_W = 16;
  localparam int SAMPLE_W    = 18;
  localparam int GAIN_W      = 16;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_SYS = 2'd0,
    CMD_PUSH_MIC = 2'd1,
    CMD_FLUSH    = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ORIGIN_MIX = 2'd0,
    ORIGIN_SYS = 2'd1,
    ORIGIN_MIC = 2'd2
  } origin_e;

  // Register word indexes (byte address / 4)
  localparam logic [1:0] REG_OUT_CHANNELS = 2'd0;
  localparam logic [1:0] REG_SYSTEM_GAIN  = 2'd1;
  localparam logic [1:0] REG_MIC_GAIN     = 2'd2;

  localparam logic [1:0]        OUT_CHANNELS_RESET = 2'd2;
  localparam logic [1:0]        OUT_CHANNELS_MONO  = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_UNITY         = 16'd4096;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } entry_t;

  typedef struct packed {
    origin_e mode;
    logic    mono;
  } mix_ctrl_t;

endpackage

// File: hdl/amix_gain_lane.sv
// One gain lane: Q1.15 sample times Q4.12 gain, rounded and saturated to Q3.15.
module amix_gain_lane (
  input  logic                                    clk,
  input  logic signed [amix_pkg::IN_SAMPLE_W-1:0] sample,
  input  logic        [amix_pkg::GAIN_W-1:0]      gain,
  output logic signed [amix_pkg::SAMPLE_W-1:0]    gained
);

  localparam int PROD_W  = amix_pkg::IN_SAMPLE_W + amix_pkg::GAIN_W + 1;
  localparam int SHIFT   = 12;
  localparam int SHIFT_W = PROD_W - SHIFT;

  localparam logic signed [SHIFT_W-1:0] Q315_MAX = SHIFT_W'(131071);
  localparam logic signed [SHIFT_W-1:0] Q315_MIN = -SHIFT_W'(131072);

  logic signed [PROD_W-1:0]  product;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [SHIFT_W-1:0] shifted;

  always_ff @(posedge clk) begin
    product <= sample * $signed({1'b0, gain});
  end

  // Add half an LSB, then floor shift: round to nearest, halves up
  assign rounded = product + PROD_W'(2048);
  assign shifted = rounded[PROD_W-1:SHIFT];

  always_comb begin
    if (shifted > Q315_MAX) begin
      gained = amix_pkg::SAMPLE_W'(Q315_MAX);
    end else if (shifted < Q315_MIN) begin
      gained = amix_pkg::SAMPLE_W'(Q315_MIN);
    end else begin
      gained = shifted[amix_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

// File: hdl/amix_fifo.sv
// Frame FIFO for one source: memory with head and fill pointers, registered read.
module amix_fifo #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         push,
  input  amix_pkg::entry_t             wdata,
  input  logic                         pop,
  output amix_pkg::entry_t             rdata,
  output logic [$clog2(DEPTH+1)-1:0]   fill
);

  localparam int HEAD_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  amix_pkg::entry_t mem [DEPTH];

  logic [HEAD_W-1:0] head;
  logic [SUM_W-1:0]  wsum;
  logic [HEAD_W-1:0] waddr;
  logic              full;

  assign full = (fill == FILL_W'(DEPTH));
  assign wsum = SUM_W'(head) + SUM_W'(fill);

  // Sum stays below twice the depth: one subtract wraps it
  always_comb begin
    if (wsum >= SUM_W'(DEPTH)) begin
      waddr = HEAD_W'(wsum - SUM_W'(DEPTH));
    end else begin
      waddr = HEAD_W'(wsum);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      head <= '0;
      fill <= '0;
    end else if (push) begin
      // drop the frame when full
      if (!full) begin
        fill <= fill + FILL_W'(1);
      end
    end else if (pop) begin
      fill <= fill - FILL_W'(1);
      head <= (head == HEAD_W'(DEPTH - 1)) ? '0 : head + HEAD_W'(1);
    end
  end

endmodule

// File: hdl/amix_merge.sv
// Merging stage: sums the two source frames with a Q1.15 clamp or passes one through; mono zeroes the right.
module amix_merge (
  input  amix_pkg::mix_ctrl_t                   ctrl,
  input  amix_pkg::entry_t                      sys_entry,
  input  amix_pkg::entry_t                      mic_entry,
  output logic signed [amix_pkg::SAMPLE_W-1:0]  left,
  output logic signed [amix_pkg::SAMPLE_W-1:0]  right
);

  localparam int SUM_W = amix_pkg::SAMPLE_W + 1;
  localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] MIX_MIN = -SUM_W'(32768);

  logic signed [SUM_W-1:0]             sum_l;
  logic signed [SUM_W-1:0]             sum_r;
  logic signed [amix_pkg::SAMPLE_W-1:0] clamp_l;
  logic signed [amix_pkg::SAMPLE_W-1:0] clamp_r;
  logic signed [amix_pkg::SAMPLE_W-1:0] pick_r;

  function automatic logic signed [amix_pkg::SAMPLE_W-1:0] clamp_mix(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [amix_pkg::SAMPLE_W-1:0] res;
    if (v > MIX_MAX) begin
      res = amix_pkg::SAMPLE_W'(MIX_MAX);
    end else if (v < MIX_MIN) begin
      res = amix_pkg::SAMPLE_W'(MIX_MIN);
    end else begin
      res = v[amix_pkg::SAMPLE_W-1:0];
    end
    return res;
  endfunction

  assign sum_l   = SUM_W'(sys_entry.left) + SUM_W'(mic_entry.left);
  assign sum_r   = SUM_W'(sys_entry.right) + SUM_W'(mic_entry.right);
  assign clamp_l = clamp_mix(sum_l);
  assign clamp_r = clamp_mix(sum_r);

  always_comb begin
    unique case (ctrl.mode)
      amix_pkg::ORIGIN_MIX: begin
        left   = clamp_l;
        pick_r = clamp_r;
      end
      amix_pkg::ORIGIN_SYS: begin
        left   = sys_entry.left;
        pick_r = sys_entry.right;
      end
      amix_pkg::ORIGIN_MIC: begin
        left   = mic_entry.left;
        pick_r = mic_entry.right;
      end
      default: begin
        left   = '0;
        pick_r = '0;
      end
    endcase
    right = ctrl.mono ? '0 : pick_r;
  end

endmodule

// File: hdl/two_source_chunked_audio_mixer_core.sv
// Top level of the two-source chunked audio mixer: config port, sequencer, lanes, FIFOs, merge.
//
//  Channel   Direction  Handshake              Payload
//  config    in/out     APB psel/penable       paddr, pwdata, prdata
//  frame in  in         in_valid / in_stall    command, in_channels, first/second_sample,
//                                              end_of_push
//  frame out out        out_valid / out_stall  left/right_sample, frame_origin, end_of_block
//
// A push passes through accept, multiply and FIFO write; clear acts on acceptance.
// Each emitted part takes a decision state, then a read and a load state per frame, as set by the
// single registered read port of each store feeding the one output register.
// rst clears the pointers, registers and sequencer; the stores are not initialised.
// out_stall holds the output register and the sequencer; in_stall is high while busy.
module two_source_chunked_audio_mixer_core #(
  parameter int FIFO_FRAMES  = 32,
  parameter int CHUNK_FRAMES = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic        [amix_pkg::ADDR_W-1:0]       paddr,
  input  logic        [amix_pkg::DATA_W-1:0]       pwdata,
  output logic        [amix_pkg::DATA_W-1:0]       prdata,
  output logic                                     pready,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic        [1:0]                        command,
  input  logic        [3:0]                        in_channels,
  input  logic signed [amix_pkg::IN_SAMPLE_W-1:0]  first_sample,
  input  logic signed [amix_pkg::IN_SAMPLE_W-1:0]  second_sample,
  input  logic                                     end_of_push,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [amix_pkg::SAMPLE_W-1:0]     left_sample,
  output logic signed [amix_pkg::SAMPLE_W-1:0]     right_sample,
  output logic        [1:0]                        frame_origin,
  output logic                                     end_of_block
);

  localparam int FILL_W  = $clog2(FIFO_FRAMES + 1);
  localparam int CHUNK_W = $clog2(CHUNK_FRAMES + 1);
  localparam int CNT_W   = (FILL_W > CHUNK_W) ? FILL_W : CHUNK_W;
  localparam logic [CNT_W-1:0] CHUNK_C = CNT_W'(CHUNK_FRAMES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WRITE,
    S_DECIDE,
    S_READ,
    S_LOAD
  } state_t;

  state_t state;

  // configuration registers
  logic [1:0]                  out_channels;
  logic [amix_pkg::GAIN_W-1:0] system_gain;
  logic [amix_pkg::GAIN_W-1:0] mic_gain;

  // latched input frame
  logic signed [amix_pkg::IN_SAMPLE_W-1:0] first_q;
  logic signed [amix_pkg::IN_SAMPLE_W-1:0] second_q;
  logic [3:0]                              ch_q;
  logic                                    eop_q;
  logic                                    src_mic;
  logic                                    flush_mode;

  amix_pkg::origin_e mode;
  logic [CNT_W-1:0]  count;
  logic              last_frame;

  logic                                 in_acc;
  logic                                 cfg_wr;
  logic                                 mono;
  logic [amix_pkg::GAIN_W-1:0]          gain_sel;
  logic signed [amix_pkg::SAMPLE_W-1:0] gain_l;
  logic signed [amix_pkg::SAMPLE_W-1:0] gain_r;
  amix_pkg::entry_t                     wentry;
  amix_pkg::entry_t                     sys_rdata;
  amix_pkg::entry_t                     mic_rdata;
  logic [FILL_W-1:0]                    sys_fill;
  logic [FILL_W-1:0]                    mic_fill;
  logic [CNT_W-1:0]                     sys_cnt;
  logic [CNT_W-1:0]                     mic_cnt;
  logic                                 sys_push;
  logic                                 mic_push;
  logic                                 sys_pop;
  logic                                 mic_pop;
  logic                                 fifo_clear;
  amix_pkg::mix_ctrl_t                  mctrl;
  logic signed [amix_pkg::SAMPLE_W-1:0] mix_l;
  logic signed [amix_pkg::SAMPLE_W-1:0] mix_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_channels <= amix_pkg::OUT_CHANNELS_RESET;
      system_gain  <= amix_pkg::GAIN_UNITY;
      mic_gain     <= amix_pkg::GAIN_UNITY;
    end else if (cfg_wr) begin
      unique case (paddr[amix_pkg::ADDR_W-1:2])
        amix_pkg::REG_OUT_CHANNELS: out_channels <= pwdata[1:0];
        amix_pkg::REG_SYSTEM_GAIN:  system_gain  <= pwdata[amix_pkg::GAIN_W-1:0];
        amix_pkg::REG_MIC_GAIN:     mic_gain     <= pwdata[amix_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[amix_pkg::ADDR_W-1:2])
      amix_pkg::REG_OUT_CHANNELS: prdata = amix_pkg::DATA_W'(out_channels);
      amix_pkg::REG_SYSTEM_GAIN:  prdata = amix_pkg::DATA_W'(system_gain);
      amix_pkg::REG_MIC_GAIN:     prdata = amix_pkg::DATA_W'(mic_gain);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- gain lanes ----------------
  assign mono     = (out_channels == amix_pkg::OUT_CHANNELS_MONO);
  assign gain_sel = src_mic ? mic_gain : system_gain;

  amix_gain_lane u_lane_l (
    .clk    (clk),
    .sample (first_q),
    .gain   (gain_sel),
    .gained (gain_l)
  );

  amix_gain_lane u_lane_r (
    .clk    (clk),
    .sample (second_q),
    .gain   (gain_sel),
    .gained (gain_r)
  );

  // mono stores zero; matching stereo keeps the second lane; otherwise spread the first
  always_comb begin
    wentry.left = gain_l;
    if (mono) begin
      wentry.right = '0;
    end else if (ch_q == 4'd2) begin
      wentry.right = gain_r;
    end else begin
      wentry.right = gain_l;
    end
  end

  // ---------------- FIFOs ----------------
  assign in_stall   = (state != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign fifo_clear = in_acc && (amix_pkg::cmd_e'(command) == amix_pkg::CMD_CLEAR);
  assign sys_push   = (state == S_WRITE) && !src_mic;
  assign mic_push   = (state == S_WRITE) && src_mic;
  assign sys_pop    = (state == S_READ) && (mode != amix_pkg::ORIGIN_MIC);
  assign mic_pop    = (state == S_READ) && (mode != amix_pkg::ORIGIN_SYS);

  amix_fifo #(.DEPTH(FIFO_FRAMES)) u_fifo_sys (
    .clk   (clk),
    .rst   (rst),
    .clear (fifo_clear),
    .push  (sys_push),
    .wdata (wentry),
    .pop   (sys_pop),
    .rdata (sys_rdata),
    .fill  (sys_fill)
  );

  amix_fifo #(.DEPTH(FIFO_FRAMES)) u_fifo_mic (
    .clk   (clk),
    .rst   (rst),
    .clear (fifo_clear),
    .push  (mic_push),
    .wdata (wentry),
    .pop   (mic_pop),
    .rdata (mic_rdata),
    .fill  (mic_fill)
  );

  assign sys_cnt = CNT_W'(sys_fill);
  assign mic_cnt = CNT_W'(mic_fill);

  // ---------------- merge ----------------
  assign mctrl.mode = mode;
  assign mctrl.mono = mono;

  amix_merge u_merge (
    .ctrl      (mctrl),
    .sys_entry (sys_rdata),
    .mic_entry (mic_rdata),
    .left      (mix_l),
    .right     (mix_r)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      flush_mode   <= 1'b0;
      mode         <= amix_pkg::ORIGIN_MIX;
      count        <= '0;
      last_frame   <= 1'b0;
      src_mic      <= 1'b0;
      eop_q        <= 1'b0;
      ch_q         <= '0;
      first_q      <= '0;
      second_q     <= '0;
      left_sample  <= '0;
      right_sample <= '0;
      frame_origin <= amix_pkg::ORIGIN_MIX;
      end_of_block <= 1'b0;
    end else begin
      // drop the taken frame unless the load below refills the register
      if (out_valid && !out_stall && state != S_LOAD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            first_q    <= first_sample;
            second_q   <= second_sample;
            ch_q       <= in_channels;
            eop_q      <= end_of_push;
            src_mic    <= (amix_pkg::cmd_e'(command) == amix_pkg::CMD_PUSH_MIC);
            flush_mode <= (amix_pkg::cmd_e'(command) == amix_pkg::CMD_FLUSH);
            unique case (amix_pkg::cmd_e'(command))
              amix_pkg::CMD_PUSH_SYS, amix_pkg::CMD_PUSH_MIC: begin
                // a frame with no channels is ignored outright
                if (in_channels != 4'd0) begin
                  state <= S_MUL;
                end
              end
              amix_pkg::CMD_FLUSH: state <= S_DECIDE;
              default: ;
            endcase
          end
        end
        S_MUL: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state <= eop_q ? S_DECIDE : S_IDLE;
        end
        S_DECIDE: begin
          if (flush_mode) begin
            priority if (sys_cnt != '0 && mic_cnt != '0) begin
              mode  <= amix_pkg::ORIGIN_MIX;
              count <= (sys_cnt < mic_cnt) ? sys_cnt : mic_cnt;
              state <= S_READ;
            end else if (sys_cnt != '0) begin
              mode  <= amix_pkg::ORIGIN_SYS;
              count <= sys_cnt;
              state <= S_READ;
            end else if (mic_cnt != '0) begin
              mode  <= amix_pkg::ORIGIN_MIC;
              count <= mic_cnt;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            priority if (sys_cnt >= CHUNK_C && mic_cnt >= CHUNK_C) begin
              mode  <= amix_pkg::ORIGIN_MIX;
              count <= CHUNK_C;
              state <= S_READ;
            end else if (sys_cnt >= CHUNK_C && mic_cnt == '0) begin
              mode  <= amix_pkg::ORIGIN_SYS;
              count <= CHUNK_C;
              state <= S_READ;
            end else if (mic_cnt >= CHUNK_C && sys_cnt == '0) begin
              mode  <= amix_pkg::ORIGIN_MIC;
              count <= CHUNK_C;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_READ: begin
          last_frame <= (count == CNT_W'(1));
          count      <= count - CNT_W'(1);
          state      <= S_LOAD;
        end
        S_LOAD: begin
          // hold the read data until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            left_sample  <= mix_l;
            right_sample <= mix_r;
            frame_origin <= mode;
            end_of_block <= last_frame;
            state        <= (count == '0) ? S_DECIDE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/amix_checker.sv
// Port-level checks for the audio mixer core and the bind that attaches them.
module amix_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [1:0]                           command,
  input logic [3:0]                           in_channels,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [amix_pkg::SAMPLE_W-1:0] left_sample,
  input logic signed [amix_pkg::SAMPLE_W-1:0] right_sample,
  input logic [1:0]                           frame_origin,
  input logic                                 end_of_block
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_sample) && $stable(right_sample)
      && $stable(frame_origin) && $stable(end_of_block))
    else $error("stalled output transfer changed");

  // a real push keeps the block busy while the gain lanes work
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (command == amix_pkg::CMD_PUSH_SYS || command == amix_pkg::CMD_PUSH_MIC)
      && in_channels != 4'd0 |=> in_stall)
    else $error("push did not hold off the next transfer");

  // clear emits nothing
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && command == amix_pkg::CMD_CLEAR |=> !$rose(out_valid))
    else $error("clear produced an output transfer");

  // mixed frames are clamped to Q1.15
  a_mix_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_origin == amix_pkg::ORIGIN_MIX |->
      (left_sample >= -18'sd32768 && left_sample <= 18'sd32767
       && right_sample >= -18'sd32768 && right_sample <= 18'sd32767))
    else $error("mixed frame outside Q1.15");

endmodule

bind two_source_chunked_audio_mixer_core amix_checker u_amix_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .command      (command),
  .in_channels  (in_channels),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .left_sample  (left_sample),
  .right_sample (right_sample),
  .frame_origin (frame_origin),
  .end_of_block (end_of_block)
);

// File: bench/two_source_chunked_audio_mixer_core_tb.sv
// Self-checking testbench for the two-source chunked audio mixer core.
module two_source_chunked_audio_mixer_core_tb;

  localparam int FIFO_DEPTH    = 32;
  localparam int CHUNK         = 16;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    amix_pkg::cmd_e                          cmd;
    logic [3:0]                              ch;
    logic signed [amix_pkg::IN_SAMPLE_W-1:0] s0;
    logic signed [amix_pkg::IN_SAMPLE_W-1:0] s1;
    logic                                    eop;
  } frame_t;

  typedef struct packed {
    logic signed [amix_pkg::SAMPLE_W-1:0] left;
    logic signed [amix_pkg::SAMPLE_W-1:0] right;
    amix_pkg::origin_e                    origin;
    logic                                 eob;
  } mix_out_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    mix_out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [amix_pkg::ADDR_W-1:0] paddr = '0;
  logic [amix_pkg::DATA_W-1:0] pwdata = '0;
  logic [amix_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = amix_pkg::CMD_FLUSH;
  logic [3:0] in_channels = '0;
  logic signed [amix_pkg::IN_SAMPLE_W-1:0] first_sample = '0;
  logic signed [amix_pkg::IN_SAMPLE_W-1:0] second_sample = '0;
  logic end_of_push = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [amix_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [amix_pkg::SAMPLE_W-1:0] right_sample;
  logic [1:0] frame_origin;
  logic end_of_block;

  two_source_chunked_audio_mixer_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .in_channels(in_channels), .first_sample(first_sample),
    .second_sample(second_sample), .end_of_push(end_of_push),
    .out_valid(out_valid), .out_stall(out_stall), .left_sample(left_sample),
    .right_sample(right_sample), .frame_origin(frame_origin),
    .end_of_block(end_of_block)
  );

  always #2 clk = ~clk;

  // Predictor state: register copies, per-source backlogs, frames still owed
  logic [1:0]                  cfg_out_channels = amix_pkg::OUT_CHANNELS_RESET;
  logic [amix_pkg::GAIN_W-1:0] cfg_sys_gain = amix_pkg::GAIN_UNITY;
  logic [amix_pkg::GAIN_W-1:0] cfg_mic_gain = amix_pkg::GAIN_UNITY;
  amix_pkg::entry_t sys_backlog[$];
  amix_pkg::entry_t mic_backlog[$];
  mix_out_t         pending_frames[$];

  bit gaps_on = 1'b1;
  int errors = 0;
  int frames_sent = 0;
  int frames_seen = 0;
  int mixed_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  function automatic logic signed [amix_pkg::SAMPLE_W-1:0] scale_sample(
      logic signed [amix_pkg::IN_SAMPLE_W-1:0] s, logic [amix_pkg::GAIN_W-1:0] g);
    longint p;
    // round half up, floor shift
    p = (longint'(s) * longint'(g) + 2048) >>> 12;
    if (p > 131071) p = 131071;
    else if (p < -131072) p = -131072;
    return p[amix_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [amix_pkg::SAMPLE_W-1:0] clamp_mix(int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[amix_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic void owe_frame(logic signed [amix_pkg::SAMPLE_W-1:0] l,
                                    logic signed [amix_pkg::SAMPLE_W-1:0] r,
                                    amix_pkg::origin_e o, logic eob);
    mix_out_t m;
    m.left   = l;
    m.right  = (cfg_out_channels == amix_pkg::OUT_CHANNELS_MONO) ? '0 : r;
    m.origin = o;
    m.eob    = eob;
    pending_frames.push_back(m);
  endfunction

  function automatic void drain_mixed(int count);
    amix_pkg::entry_t a;
    amix_pkg::entry_t b;
    for (int k = 0; k < count; k++) begin
      a = sys_backlog.pop_front();
      b = mic_backlog.pop_front();
      owe_frame(clamp_mix(int'(a.left) + int'(b.left)),
                clamp_mix(int'(a.right) + int'(b.right)), amix_pkg::ORIGIN_MIX,
                k == count - 1);
    end
  endfunction

  function automatic void drain_single(bit from_mic, int count);
    amix_pkg::entry_t a;
    for (int k = 0; k < count; k++) begin
      a = from_mic ? mic_backlog.pop_front() : sys_backlog.pop_front();
      owe_frame(a.left, a.right, from_mic ? amix_pkg::ORIGIN_MIC : amix_pkg::ORIGIN_SYS,
                k == count - 1);
    end
  endfunction

  function automatic void advance_mixer(frame_t f);
    logic                        mono;
    logic [amix_pkg::GAIN_W-1:0] g;
    amix_pkg::entry_t            e;
    int                          common;
    case (f.cmd)
      amix_pkg::CMD_PUSH_SYS, amix_pkg::CMD_PUSH_MIC: begin
        if (f.ch != 4'd0) begin
          mono = (cfg_out_channels == amix_pkg::OUT_CHANNELS_MONO);
          g = (f.cmd == amix_pkg::CMD_PUSH_SYS) ? cfg_sys_gain : cfg_mic_gain;
          e.left = scale_sample(f.s0, g);
          if (mono) e.right = '0;
          else if (f.ch == 4'd2) e.right = scale_sample(f.s1, g);
          else e.right = e.left;
          // drop the frame when the backlog is full
          if (f.cmd == amix_pkg::CMD_PUSH_SYS) begin
            if (sys_backlog.size() < FIFO_DEPTH) sys_backlog.push_back(e);
          end else begin
            if (mic_backlog.size() < FIFO_DEPTH) mic_backlog.push_back(e);
          end
          if (f.eop) begin
            while (sys_backlog.size() >= CHUNK && mic_backlog.size() >= CHUNK)
              drain_mixed(CHUNK);
            while (sys_backlog.size() >= CHUNK && mic_backlog.size() == 0)
              drain_single(1'b0, CHUNK);
            while (mic_backlog.size() >= CHUNK && sys_backlog.size() == 0)
              drain_single(1'b1, CHUNK);
          end
        end
      end
      amix_pkg::CMD_FLUSH: begin
        common = (sys_backlog.size() < mic_backlog.size()) ?
                 sys_backlog.size() : mic_backlog.size();
        drain_mixed(common);
        drain_single(1'b0, sys_backlog.size());
        drain_single(1'b1, mic_backlog.size());
      end
      default: begin
        sys_backlog.delete();
        mic_backlog.delete();
      end
    endcase
  endfunction

  function automatic frame_t make_frame(amix_pkg::cmd_e cmd, int ch, int s0, int s1, bit eop);
    frame_t f;
    f.cmd = cmd;
    f.ch  = ch[3:0];
    f.s0  = s0[amix_pkg::IN_SAMPLE_W-1:0];
    f.s1  = s1[amix_pkg::IN_SAMPLE_W-1:0];
    f.eop = eop;
    return f;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic send_frame(frame_t f);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= f.cmd;
    in_channels   <= f.ch;
    first_sample  <= f.s0;
    second_sample <= f.s1;
    end_of_push   <= f.eop;
    do @(posedge clk); while (in_stall);
    if (!(f.cmd inside {amix_pkg::CMD_PUSH_SYS, amix_pkg::CMD_PUSH_MIC}) || f.ch != 4'd0)
      frames_sent++;
  endtask

  task automatic play_frame(frame_t f);
    send_frame(f);
    advance_mixer(f);
  endtask

  task automatic set_register(logic [1:0] idx, logic [amix_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      amix_pkg::REG_OUT_CHANNELS: cfg_out_channels = val[1:0];
      amix_pkg::REG_SYSTEM_GAIN:  cfg_sys_gain = val[amix_pkg::GAIN_W-1:0];
      amix_pkg::REG_MIC_GAIN:     cfg_mic_gain = val[amix_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the input idle until every owed frame is out, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(int quota);
    int             start;
    int             pick;
    int             len;
    int             ch;
    amix_pkg::cmd_e src;
    start = frames_sent;
    while (frames_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        play_frame(make_frame(amix_pkg::CMD_FLUSH, $urandom_range(0, 15), rand_sample(),
                              rand_sample(), 1'($urandom_range(0, 1))));
      end else if (pick < 9) begin
        play_frame(make_frame(amix_pkg::CMD_CLEAR, $urandom_range(0, 15), rand_sample(),
                              rand_sample(), 1'($urandom_range(0, 1))));
      end else if (pick < 14) begin
        play_frame(make_frame(amix_pkg::cmd_e'($urandom_range(0, 1)), $urandom_range(0, 15),
                              rand_sample(), rand_sample(), 1'($urandom_range(0, 1))));
      end else begin
        // well-formed push block; a long one may overrun the backlog
        src = amix_pkg::cmd_e'($urandom_range(0, 1));
        len = (pick < 18) ? $urandom_range(30, 36) : $urandom_range(1, 20);
        ch  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 2);
        for (int i = 0; i < len; i++)
          play_frame(make_frame(src, ch, rand_sample(), rand_sample(), i == len - 1));
      end
    end
  endtask

  // Output stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (!gaps_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each output transfer with the oldest owed frame
  always @(posedge clk) begin
    mix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        $error("unexpected output frame: left %0d right %0d origin %0d",
               left_sample, right_sample, frame_origin);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (want.origin == amix_pkg::ORIGIN_MIX) mixed_seen++;
        if (left_sample !== want.left) begin
          $error("left_sample: expected %0d, got %0d", want.left, left_sample);
          errors++;
        end
        if (right_sample !== want.right) begin
          $error("right_sample: expected %0d, got %0d", want.right, right_sample);
          errors++;
        end
        if (frame_origin !== want.origin) begin
          $error("frame_origin: expected %0d, got %0d", want.origin, frame_origin);
          errors++;
        end
        if (end_of_block !== want.eob) begin
          $error("end_of_block: expected %0d, got %0d", want.eob, end_of_block);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("two_source_chunked_audio_mixer_core test failed");
      $finish;
    end
  end

  initial begin
    row_t                        rows[$];
    row_t                        r;
    int                          mark;
    logic [1:0]                  oc;
    logic [amix_pkg::GAIN_W-1:0] sg;
    logic [amix_pkg::GAIN_W-1:0] mg;

    // Directed rows; typed rows each owe exactly one frame at reset settings
    r.typed = 1'b0;
    r.want = '0;
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 2, 32767, -32768, 1'b0);  rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 0, 0, 0, 1'b0);               r.typed = 1'b1;
    r.want = '{18'sd32767, -18'sd32768, amix_pkg::ORIGIN_SYS, 1'b1};   rows.push_back(r);
    r.typed = 1'b0;
    r.f = make_frame(amix_pkg::CMD_PUSH_MIC, 2, -32768, 32767, 1'b1);  rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 15, -1, -1, 1'b1);            r.typed = 1'b1;
    r.want = '{-18'sd32768, 18'sd32767, amix_pkg::ORIGIN_MIC, 1'b1};   rows.push_back(r);
    r.typed = 1'b0;
    // channel mismatch spreads the first sample
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 1, -1, 5, 1'b0);          rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_MIC, 2, 32767, 32767, 1'b0);   rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 0, 0, 0, 1'b0);               r.typed = 1'b1;
    r.want = '{18'sd32766, 18'sd32766, amix_pkg::ORIGIN_MIX, 1'b1};    rows.push_back(r);
    r.typed = 1'b0;
    // zero channels: ignored even with end of push
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 0, 100, 100, 1'b1);       rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 0, 0, 0, 1'b0);               rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_CLEAR, 15, -1, -1, 1'b1);            rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 15, -32768, 0, 1'b1);     rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_MIC, 8, 1234, -1234, 1'b0);    rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_CLEAR, 0, 0, 0, 1'b0);               rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 0, 0, 0, 1'b0);               rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 2, -32768, -32768, 1'b0); rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_MIC, 2, -32768, -32768, 1'b0); rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 0, 0, 0, 1'b0);               r.typed = 1'b1;
    r.want = '{-18'sd32768, -18'sd32768, amix_pkg::ORIGIN_MIX, 1'b1};  rows.push_back(r);
    r.typed = 1'b0;
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 2, 1, -1, 1'b0);          rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_SYS, 2, -2, 2, 1'b0);          rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_PUSH_MIC, 1, 300, 0, 1'b0);         rows.push_back(r);
    r.f = make_frame(amix_pkg::CMD_FLUSH, 0, 0, 0, 1'b0);               rows.push_back(r);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_frame(rows[i].f);
      mark = pending_frames.size();
      advance_mixer(rows[i].f);
      if (rows[i].typed) begin
        while (pending_frames.size() > mark) void'(pending_frames.pop_back());
        pending_frames.push_back(rows[i].want);
      end
    end
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin oc = amix_pkg::OUT_CHANNELS_MONO;  sg = 16'hFFFF; mg = 16'd0;    end
        1: begin oc = 2'd0;                         sg = 16'd0;    mg = 16'hFFFF; end
        2: begin oc = amix_pkg::OUT_CHANNELS_RESET; sg = 16'hFFFF; mg = 16'hFFFF; end
        3: begin oc = 2'd3; sg = 16'($urandom); mg = 16'($urandom);               end
        4: begin
          oc = amix_pkg::OUT_CHANNELS_MONO;
          sg = 16'($urandom_range(0, 8192));
          mg = 16'($urandom_range(0, 8192));
        end
        default: begin
          oc = amix_pkg::OUT_CHANNELS_RESET;
          sg = amix_pkg::GAIN_UNITY;
          mg = 16'($urandom_range(2048, 6144));
        end
      endcase
      // no idling in the middle stretch and the closing phase
      gaps_on = (ph != 3) && (ph != 5);
      set_register(amix_pkg::REG_OUT_CHANNELS, amix_pkg::DATA_W'(oc));
      set_register(amix_pkg::REG_SYSTEM_GAIN, amix_pkg::DATA_W'(sg));
      set_register(amix_pkg::REG_MIC_GAIN, amix_pkg::DATA_W'(mg));
      settings_used++;
      random_traffic(40);
      settle();
    end

    $display("Run covered %0d input transfers and %0d output frames (%0d mixed)",
             frames_sent, frames_seen, mixed_seen);
    $display("across %0d register settings, mono and stereo, gains at both extremes",
             settings_used);
    if (errors == 0)
      $display("two_source_chunked_audio_mixer_core test passed");
    else
      $display("two_source_chunked_audio_mixer_core test failed");
    $finish;
  end

endmodule
